FILE: src/cmt_pkg.sv
// Shared types, constants and character helpers for the CMT record extractor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package cmt_pkg;

  localparam int MAX_RECORD = 8192;
  localparam int REC_LEN_W  = 14;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_LO_R = 8'h72;
  localparam logic [7:0] CH_LO_N = 8'h6E;
  localparam logic [7:0] CH_LO_X = 8'h78;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic [2:0]  MARK_LEN  = 3'd6;
  localparam logic [31:0] MARK_HEAD = 32'h544D432B;  // "+CMT"
  localparam logic [31:0] MARK_TAIL = 32'h0000203A;  // ": "

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_PDU    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_COMMIT = 2'd1,
    KIND_ABORT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] chars;
    logic [2:0]  count;
    kind_t       kind;
  } result_t;

  // one queue word: the results caused by one input byte
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  function automatic logic [7:0] mark_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h2B;  // +
      3'd1:    c = 8'h43;  // C
      3'd2:    c = 8'h4D;  // M
      3'd3:    c = 8'h54;  // T
      3'd4:    c = 8'h3A;  // :
      3'd5:    c = 8'h20;  // space
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic result_t escape_byte(input logic [7:0] b);
    result_t r;
    r.kind = KIND_TEXT;
    if (b == CH_CR) begin
      r.chars = {16'd0, CH_LO_R, CH_BSL};
      r.count = 3'd2;
    end else if (b == CH_LF) begin
      r.chars = {16'd0, CH_LO_N, CH_BSL};
      r.count = 3'd2;
    end else if (b == CH_BSL) begin
      r.chars = {16'd0, CH_BSL, CH_BSL};
      r.count = 3'd2;
    end else if (b >= PRINT_LO && b <= PRINT_HI) begin
      r.chars = {24'd0, b};
      r.count = 3'd1;
    end else begin
      r.chars = {hex_char(b[3:0]), hex_char(b[7:4]), CH_LO_X, CH_BSL};
      r.count = 3'd4;
    end
    return r;
  endfunction

endpackage

FILE: src/cmt_front.sv
// Front end: marker hunt, line tracking and escaping; at most one queue word per byte.
// Depends on cmt_pkg.
`timescale 1ns / 1ps

module cmt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      in_byte,
  output logic            q_wr,
  output cmt_pkg::entry_t q_data
);

  cmt_pkg::phase_t                   phase_r, phase_nxt;
  logic [2:0]                        marker_pos_r, marker_pos_nxt;
  logic                              prev_cr_r, prev_cr_nxt;
  logic                              pdu_cr_first_r, pdu_cr_first_nxt;
  logic                              pdu_started_r, pdu_started_nxt;
  logic [cmt_pkg::REC_LEN_W-1:0]     rec_len_r, rec_len_nxt;

  logic                              in_record;
  logic                              pos_hit;
  logic [2:0]                        pos_step;
  logic                              mark_done;
  logic [cmt_pkg::REC_LEN_W-1:0]     len_inc;
  logic                              line_end;
  logic                              is_cr;
  logic                              commit;
  logic                              abort_rec;

  assign in_record = (phase_r == cmt_pkg::PH_HEADER) || (phase_r == cmt_pkg::PH_PDU);
  assign pos_hit   = (marker_pos_r < cmt_pkg::MARK_LEN) &&
                     (in_byte == cmt_pkg::mark_char(marker_pos_r));
  assign pos_step  = pos_hit ? (marker_pos_r + 3'd1) :
                     ((in_byte == cmt_pkg::CH_PLUS) ? 3'd1 : 3'd0);
  assign mark_done = (pos_step == cmt_pkg::MARK_LEN);
  assign len_inc   = rec_len_r + {{(cmt_pkg::REC_LEN_W-1){1'b0}}, 1'b1};
  assign is_cr     = (in_byte == cmt_pkg::CH_CR);
  assign line_end  = (in_byte == cmt_pkg::CH_LF) && prev_cr_r;
  assign commit    = (phase_r == cmt_pkg::PH_PDU) && line_end && !pdu_cr_first_r;
  // empty PDU line, or the length limit reached without a commit
  assign abort_rec = ((phase_r == cmt_pkg::PH_PDU) && line_end && pdu_cr_first_r) ||
                     (!commit && (len_inc >= cmt_pkg::REC_LEN_W'(cmt_pkg::MAX_RECORD)));

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    marker_pos_nxt   = marker_pos_r;
    prev_cr_nxt      = prev_cr_r;
    pdu_cr_first_nxt = pdu_cr_first_r;
    pdu_started_nxt  = pdu_started_r;
    rec_len_nxt      = rec_len_r;
    if (accept) begin
      if (!in_record) begin
        phase_nxt = cmt_pkg::PH_HUNT;
        if (mark_done) begin
          phase_nxt        = cmt_pkg::PH_HEADER;
          marker_pos_nxt   = 3'd0;
          prev_cr_nxt      = 1'b0;
          pdu_cr_first_nxt = 1'b0;
          pdu_started_nxt  = 1'b0;
          rec_len_nxt      = cmt_pkg::REC_LEN_W'(6);
        end else begin
          marker_pos_nxt = pos_step;
        end
      end else begin
        rec_len_nxt = len_inc;
        if (phase_r == cmt_pkg::PH_HEADER) begin
          if (line_end) begin
            phase_nxt        = cmt_pkg::PH_PDU;
            prev_cr_nxt      = 1'b0;
            pdu_cr_first_nxt = 1'b0;
            pdu_started_nxt  = 1'b0;
          end else begin
            prev_cr_nxt = is_cr;
          end
        end else if (!line_end) begin
          prev_cr_nxt      = is_cr;
          pdu_cr_first_nxt = !pdu_started_r && is_cr;
          pdu_started_nxt  = 1'b1;
        end
        // record done either way: back to hunting
        if (commit || abort_rec) begin
          phase_nxt        = cmt_pkg::PH_HUNT;
          marker_pos_nxt   = 3'd0;
          prev_cr_nxt      = 1'b0;
          pdu_cr_first_nxt = 1'b0;
          pdu_started_nxt  = 1'b0;
          rec_len_nxt      = '0;
        end
      end
    end
  end

  // outputs
  always_comb begin
    q_wr   = accept && (in_record || mark_done);
    q_data = '0;
    if (in_record) begin
      q_data.first = cmt_pkg::escape_byte(in_byte);
      if (commit) begin
        q_data.second.chars = {24'd0, cmt_pkg::CH_LF};
        q_data.second.count = 3'd1;
        q_data.second.kind  = cmt_pkg::KIND_COMMIT;
      end else begin
        q_data.second.chars = '0;
        q_data.second.count = 3'd0;
        q_data.second.kind  = cmt_pkg::KIND_ABORT;
      end
      q_data.two = commit || abort_rec;
    end else begin
      q_data.first.chars  = cmt_pkg::MARK_HEAD;
      q_data.first.count  = 3'd4;
      q_data.first.kind   = cmt_pkg::KIND_TEXT;
      q_data.second.chars = cmt_pkg::MARK_TAIL;
      q_data.second.count = 3'd2;
      q_data.second.kind  = cmt_pkg::KIND_TEXT;
      q_data.two          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= cmt_pkg::PH_HUNT;
      marker_pos_r   <= 3'd0;
      prev_cr_r      <= 1'b0;
      pdu_cr_first_r <= 1'b0;
      pdu_started_r  <= 1'b0;
      rec_len_r      <= '0;
    end else begin
      phase_r        <= phase_nxt;
      marker_pos_r   <= marker_pos_nxt;
      prev_cr_r      <= prev_cr_nxt;
      pdu_cr_first_r <= pdu_cr_first_nxt;
      pdu_started_r  <= pdu_started_nxt;
      rec_len_r      <= rec_len_nxt;
    end
  end

endmodule

FILE: src/cmt_fifo.sv
// Short word queue between front and back, first word visible at the head.
// Depends on cmt_pkg.
`timescale 1ns / 1ps

module cmt_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr,
  input  cmt_pkg::entry_t wr_data,
  input  logic            rd,
  output cmt_pkg::entry_t rd_data,
  output logic            full,
  output logic            empty
);

  cmt_pkg::entry_t             mem_r [cmt_pkg::QDEPTH];
  logic [cmt_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cmt_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cmt_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        do_wr;
  logic                        do_rd;

  assign full    = (cnt_r == cmt_pkg::QCNT_W'(cmt_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (do_wr ? {{(cmt_pkg::QPTR_W-1){1'b0}}, 1'b1} : '0);
    rd_ptr_nxt = rd_ptr_r + (do_rd ? {{(cmt_pkg::QPTR_W-1){1'b0}}, 1'b1} : '0);
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + {{(cmt_pkg::QCNT_W-1){1'b0}}, 1'b1};
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - {{(cmt_pkg::QCNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: src/cmt_back.sv
// Back end: unpacks queue words into single results behind an output register.
// Depends on cmt_pkg.
`timescale 1ns / 1ps

module cmt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  cmt_pkg::entry_t  q_data,
  output logic             q_rd,
  input  logic             pop,
  output logic             out_valid,
  output cmt_pkg::result_t out_res,
  output logic             out_last
);

  logic             out_valid_r, out_valid_nxt;
  cmt_pkg::result_t out_res_r, out_res_nxt;
  logic             out_last_r, out_last_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  cmt_pkg::result_t pend_res_r, pend_res_nxt;
  logic             load;

  // output slot is free this cycle or its word is being taken
  assign load = !out_valid_r || pop;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_res_nxt   = pend_res_r;
    q_rd           = 1'b0;
    if (load) begin
      if (pend_valid_r) begin
        // finish the current byte before taking the next word
        out_valid_nxt  = 1'b1;
        out_res_nxt    = pend_res_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
      end else if (!q_empty) begin
        q_rd           = 1'b1;
        out_valid_nxt  = 1'b1;
        out_res_nxt    = q_data.first;
        out_last_nxt   = !q_data.two;
        pend_valid_nxt = q_data.two;
        pend_res_nxt   = q_data.second;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

FILE: src/cmt_record_extractor.sv
// One byte per cycle is taken while the queue is not full; a byte with two results
// gives two outputs; a four-word queue between front and back absorbs the difference.
// The back end sets the output side, moving one result per cycle while pop is high.
// Reset (synchronous, rst_n low) returns to marker hunting with queue and output empty.
// Depends on cmt_pkg, cmt_front, cmt_fifo, cmt_back.
`timescale 1ns / 1ps

module cmt_record_extractor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_chars,
  output logic [2:0]  out_count,
  output logic [1:0]  out_kind,
  output logic        out_last
);

  logic             accept;
  logic             q_wr;
  cmt_pkg::entry_t  q_wdata;
  logic             q_rd;
  cmt_pkg::entry_t  q_rdata;
  logic             q_full;
  logic             q_empty;
  logic             out_valid;
  cmt_pkg::result_t out_res;

  assign full   = q_full;
  assign accept = push && !q_full;

  cmt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .q_wr    (q_wr),
    .q_data  (q_wdata)
  );

  cmt_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  cmt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (out_last)
  );

  assign empty     = !out_valid;
  assign out_chars = out_res.chars;
  assign out_count = out_res.count;
  assign out_kind  = out_res.kind;

endmodule
